// ===== rtl/mono_page_framebuffer_blitter_defines.svh =====
`ifndef MONO_PAGE_FRAMEBUFFER_BLITTER_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_BLITTER_DEFINES_SVH

// concurrent check on the rising edge, held off while reset is asserted
`define MPFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check on the rising edge, live during reset as well
`define MPFB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared widths, codes and control types of the page framebuffer blitter.
// ----------------------------------------------------------------------------
package mpfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int PIX_PER_BYTE      = 8;

    // configuration field widths
    localparam int OX_W = 7;
    localparam int OY_W = 6;
    localparam int WW_W = 8;
    localparam int WH_W = 7;

    // item field widths
    localparam int BITS_W = 8;
    localparam int PAGE_W = 3;
    localparam int COL_W  = 7;
    localparam int DATA_W = 8;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic [OX_W-1:0] origin_x;
        logic [OY_W-1:0] origin_y;
        logic [WW_W-1:0] win_width;
        logic [WH_W-1:0] win_height;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic take;
        logic blit;
        logic rd_issue;
        logic rd_grab;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic fits;
        logic blit_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/mpfb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_in_if
// Input item channel: bitmap writes and framebuffer reads.
// ----------------------------------------------------------------------------
interface mpfb_in_if;
    import mpfb_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic              first;
    logic [BITS_W-1:0] bits;
    logic [PAGE_W-1:0] read_page;
    logic [COL_W-1:0]  read_column;

    modport source (output valid, func, first, bits, read_page, read_column, input ready);
    modport sink   (input valid, func, first, bits, read_page, read_column, output ready);
endinterface

// ===== rtl/mpfb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_out_if
// Result item channel: read data and window status.
// ----------------------------------------------------------------------------
interface mpfb_out_if;
    import mpfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              window_done;

    modport source (output valid, read_data, window_done, input ready);
    modport sink   (input valid, read_data, window_done, output ready);
endinterface

// ===== rtl/mpfb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_regs
// APB-style register file holding the blit window configuration.
// ----------------------------------------------------------------------------
module mpfb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpfb_pkg::APB_AW-1:0] paddr,
    input  logic [mpfb_pkg::APB_DW-1:0] pwdata,
    output logic [mpfb_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output mpfb_pkg::t_cfg              o_cfg
);
    import mpfb_pkg::*;

    typedef enum logic [1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_WIN_WIDTH,
        REG_WIN_HEIGHT
    } t_reg_idx;

    localparam logic [WW_W-1:0] WIN_WIDTH_RST  = WW_W'(8);
    localparam logic [WH_W-1:0] WIN_HEIGHT_RST = WH_W'(8);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.win_width  <= WIN_WIDTH_RST;
            r_cfg.win_height <= WIN_HEIGHT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ORIGIN_X:   r_cfg.origin_x   <= pwdata[OX_W-1:0];
                REG_ORIGIN_Y:   r_cfg.origin_y   <= pwdata[OY_W-1:0];
                REG_WIN_WIDTH:  r_cfg.win_width  <= pwdata[WW_W-1:0];
                REG_WIN_HEIGHT: r_cfg.win_height <= pwdata[WH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ORIGIN_X:   prdata = APB_DW'(r_cfg.origin_x);
            REG_ORIGIN_Y:   prdata = APB_DW'(r_cfg.origin_y);
            REG_WIN_WIDTH:  prdata = APB_DW'(r_cfg.win_width);
            REG_WIN_HEIGHT: prdata = APB_DW'(r_cfg.win_height);
            default:        prdata = '0;
        endcase
    end
endmodule

// ===== rtl/mpfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_ctrl
// Sequencer: screen clear, item dispatch, pixel loop and result hand-off.
// ----------------------------------------------------------------------------
module mpfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_func,
    input  mpfb_pkg::t_status i_status,
    output logic              o_in_ready,
    output mpfb_pkg::t_cmd    o_cmd
);
    import mpfb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_BLIT,
        S_READ,
        S_RWAIT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = (i_in_func == FUNC_READ) ? S_READ : S_CHECK;
                end
            end
            S_CHECK: begin
                // a byte that does not fit is ignored
                n_state = i_status.fits ? S_BLIT : S_FINISH;
            end
            S_BLIT: begin
                o_cmd.blit = 1'b1;
                if (i_status.blit_last) n_state = S_FINISH;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RWAIT;
            end
            S_RWAIT: begin
                o_cmd.rd_grab = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/mpfb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_dpath
// Frame store, cursor, pixel read-modify-write pipe and result register.
// ----------------------------------------------------------------------------
module mpfb_dpath #(
    parameter int SCREEN_WIDTH  = mpfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpfb_pkg::t_cfg              i_cfg,
    input  mpfb_pkg::t_cmd              i_cmd,
    output mpfb_pkg::t_status           o_status,
    input  logic                        i_func,
    input  logic                        i_first,
    input  logic [mpfb_pkg::BITS_W-1:0] i_bits,
    input  logic [mpfb_pkg::PAGE_W-1:0] i_read_page,
    input  logic [mpfb_pkg::COL_W-1:0]  i_read_column,
    mpfb_out_if.source                  o_result
);
    import mpfb_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH      = PAGE_COUNT * SCREEN_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int XW         = WW_W + 1;
    localparam int YW         = WH_W + 1;
    localparam int PGW        = YW - 3;
    localparam int POSW       = WW_W + WH_W + 1;

    localparam logic [XW-1:0]  X_LIM    = XW'(SCREEN_WIDTH);
    localparam logic [YW-1:0]  Y_LIM    = YW'(SCREEN_HEIGHT);
    localparam logic [PGW-1:0] PAGE_LIM = PGW'(PAGE_COUNT);
    localparam logic [AW-1:0]  ROW_STEP = AW'(SCREEN_WIDTH);
    localparam logic [AW-1:0]  LAST_IDX = AW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [WW_W-1:0]   r_dx;
    logic [WH_W-1:0]   r_dy;
    logic [WW_W-1:0]   n_dx;
    logic [WH_W-1:0]   n_dy;
    logic [2:0]        r_pix;
    logic [BITS_W-1:0] r_bits;
    logic [PAGE_W-1:0] r_page;
    logic [COL_W-1:0]  r_col;
    logic [AW-1:0]     r_clr_addr;
    logic [DATA_W-1:0] r_rdata;

    logic              r_s_valid;
    logic [AW-1:0]     r_s_addr;
    logic [DATA_W-1:0] r_s_mask;
    logic              r_s_lit;
    logic              r_w_valid;
    logic [AW-1:0]     r_w_addr;
    logic [DATA_W-1:0] r_w_data;

    logic [DATA_W-1:0] r_res_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_done;

    logic [POSW-2:0]   w_row_pos;
    logic [POSW-2:0]   w_area;
    logic [POSW-1:0]   w_pos_end;
    logic              w_fits;
    logic [XW-1:0]     w_x;
    logic [YW-1:0]     w_y;
    logic              w_on_screen;
    logic [AW-1:0]     w_pix_addr;
    logic [DATA_W-1:0] w_pix_mask;
    logic [XW-1:0]     w_dx_inc;
    logic              w_wrap;
    logic [AW-1:0]     w_rd_addr;
    logic              w_rd_ok;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_merged;
    logic [DATA_W-1:0] w_pix_wdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;

    // window fill test: row start + column + one byte of pixels against the area
    assign w_row_pos = (POSW-1)'(r_dy) * (POSW-1)'(i_cfg.win_width);
    assign w_area    = (POSW-1)'(i_cfg.win_width) * (POSW-1)'(i_cfg.win_height);
    assign w_pos_end = POSW'(w_row_pos) + POSW'(r_dx) + POSW'(PIX_PER_BYTE);
    assign w_fits    = w_pos_end <= POSW'(w_area);

    // screen position of the cursor and its store address
    assign w_x         = XW'(i_cfg.origin_x) + XW'(r_dx);
    assign w_y         = YW'(i_cfg.origin_y) + YW'(r_dy);
    assign w_on_screen = (w_x < X_LIM) && (w_y < Y_LIM);
    assign w_pix_addr  = AW'(w_y[YW-1:3]) * ROW_STEP + AW'(w_x);
    assign w_pix_mask  = DATA_W'(1) << w_y[2:0];

    assign w_dx_inc = XW'(r_dx) + XW'(1);
    assign w_wrap   = w_dx_inc >= XW'(i_cfg.win_width);
    assign n_dx     = w_wrap ? '0 : w_dx_inc[WW_W-1:0];
    assign n_dy     = w_wrap ? r_dy + WH_W'(1) : r_dy;

    assign w_rd_addr = AW'(r_page) * ROW_STEP + AW'(r_col);
    assign w_rd_ok   = (PGW'(r_page) < PAGE_LIM) && (XW'(r_col) < X_LIM);
    assign w_raddr   = i_cmd.rd_issue ? w_rd_addr : w_pix_addr;

    // the previous pixel's write is not yet visible in the read data
    assign w_merged    = (r_w_valid && (r_w_addr == r_s_addr)) ? r_w_data : r_rdata;
    assign w_pix_wdata = r_s_lit ? (w_merged | r_s_mask) : (w_merged & ~r_s_mask);

    always_comb begin
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = r_s_valid;
            w_waddr = r_s_addr;
            w_wdata = w_pix_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx        <= '0;
            r_dy        <= '0;
            r_pix       <= '0;
            r_clr_addr  <= '0;
            r_s_valid   <= 1'b0;
            r_w_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + AW'(1);

            if (i_cmd.take) begin
                r_pix <= '0;
                if (i_func == FUNC_WRITE && i_first) begin
                    r_dx <= '0;
                    r_dy <= '0;
                end
            end else if (i_cmd.blit) begin
                r_pix <= r_pix + 3'd1;
                r_dx  <= n_dx;
                r_dy  <= n_dy;
            end

            r_s_valid <= i_cmd.blit && w_on_screen;
            r_w_valid <= r_s_valid;

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_bits     <= i_bits;
            r_page     <= i_read_page;
            r_col      <= i_read_column;
            r_res_data <= '0;
        end else if (i_cmd.blit) begin
            r_bits <= r_bits << 1;
        end
        if (i_cmd.rd_grab) r_res_data <= w_rd_ok ? r_rdata : '0;

        r_s_addr <= w_pix_addr;
        r_s_mask <= w_pix_mask;
        r_s_lit  <= r_bits[BITS_W-1];
        r_w_addr <= r_s_addr;
        r_w_data <= w_pix_wdata;

        if (i_cmd.load_out) begin
            r_out_data <= r_res_data;
            r_out_done <= !w_fits;
        end
    end

    assign o_status.clear_last = r_clr_addr == LAST_IDX;
    assign o_status.fits       = w_fits;
    assign o_status.blit_last  = (n_dy >= i_cfg.win_height) || (r_pix == 3'(PIX_PER_BYTE - 1));
    assign o_status.out_free   = !r_out_valid || o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = r_out_data;
    assign o_result.window_done = r_out_done;
endmodule

// ===== rtl/mono_page_framebuffer_blitter.sv =====
`timescale 1ns / 1ps
// write item: a fit check, then a loop over up to eight pixels, then the result (no loop when the byte is ignored)
// a write ends early when the window's last row is reached; one frame store read-modify-write per pixel
// read item: one registered store read, then the result; a new item is taken only once the result is loaded
// reset: synchronous, active low; registers to defaults, then a clearing pass zeroes all
// PAGE_COUNT*SCREEN_WIDTH store bytes (1024 at default size), no items taken
// ----------------------------------------------------------------------------
// mono_page_framebuffer_blitter
// Page-organised monochrome framebuffer with a bitmap blitter and byte reads.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_blitter_defines.svh"

module mono_page_framebuffer_blitter #(
    parameter int SCREEN_WIDTH  = mpfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mpfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpfb_pkg::APB_AW-1:0] paddr,
    input  logic [mpfb_pkg::APB_DW-1:0] pwdata,
    output logic [mpfb_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    mpfb_in_if.sink                     i_item,
    mpfb_out_if.source                  o_result
);
    import mpfb_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_item.ready = w_in_ready;

    mpfb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_func  (i_item.func),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mpfb_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_func        (i_item.func),
        .i_first       (i_item.first),
        .i_bits        (i_item.bits),
        .i_read_page   (i_item.read_page),
        .i_read_column (i_item.read_column),
        .o_result      (o_result)
    );

    // one item in flight: no second accept straight after the first
    `MPFB_ASSERT(a_one_item, i_clk, i_rst_n,
        i_item.valid && i_item.ready |=> !i_item.ready, "item accepted while busy")
    // a finished result never overwrites one still waiting
    `MPFB_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        w_cmd.load_out |-> w_status.out_free, "result register overwritten")
    // after reset the block is clearing: nothing taken, nothing offered
    `MPFB_ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> !i_item.ready && !o_result.valid, "handshake active after reset")
endmodule
